FILE: src/sntab_pkg.sv
// Package for the sorted name table: input and result beat types, status codes.
// No dependencies.
package sntab_pkg;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [1:0] MODE_EXACT = 2'd0;
	localparam logic [1:0] MODE_ANY = 2'd1;

	// Width of one stored entry: names, kind, type, position, sizes, flags.
	localparam int ENTRY_W = 64 + 64 + 4 + 8 + 32 + 32 + 32 + 8;

	typedef struct packed {
		logic        action;
		logic [63:0] name_high;
		logic [63:0] name_low;
		logic [3:0]  image_kind;
		logic [7:0]  content_type;
		logic [1:0]  match_mode;
		logic [31:0] file_position;
		logic [31:0] stored_size;
		logic [31:0] full_size;
		logic [7:0]  attributes;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  slot;
		logic [10:0] entry_count;
		logic [31:0] found_position;
		logic [31:0] found_stored_size;
		logic [31:0] found_full_size;
		logic [7:0]  found_attributes;
		logic [7:0]  found_type;
	} result_t;

	typedef struct packed {
		logic [63:0] name_high;
		logic [63:0] name_low;
		logic [3:0]  kind;
		logic [7:0]  ctype;
		logic [31:0] position;
		logic [31:0] stored_size;
		logic [31:0] full_size;
		logic [7:0]  flags;
	} entry_t;

	// Comparison outcome of a stored entry against the query.
	typedef struct packed {
		logic name_gt;   // stored name sorts after the query name
		logic name_eq;
		logic kind_gt;
		logic kind_eq;
		logic type_lt;   // stored type below query type (sorts after)
		logic type_eq;
	} cmp_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
		return r;
	endfunction

endpackage

FILE: src/sntab_datapath.sv
// Datapath of the sorted name table: entry memory, search bounds, compare and shift.
// Depends on sntab_pkg.
module sntab_datapath #(
	parameter int AW = 10,
	parameter int DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sntab_pkg::item_t     item_in,
	input  logic                 cap,          // capture query, set bounds
	input  logic                 rd_mid,       // read entry at midpoint
	input  logic                 step,         // update bounds from compare
	input  logic                 rd_shift,     // read entry at shift pointer - 1
	input  logic                 wr_shift,     // write that entry at shift pointer
	input  logic                 wr_new,       // store new entry at left
	output logic                 search_done,  // left > right
	output logic                 shift_done,   // shift pointer reached left
	output logic                 full,
	output logic                 hit,          // midpoint entry matches lookup
	output logic [AW:0]          left_out,
	output logic [AW:0]          mid_out,
	output logic [AW:0]          cnt_out,
	output sntab_pkg::entry_t    rd_data_out
);
	import sntab_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;
	item_t  qry_q;
	logic [AW:0] cnt_q, left_q, ptr_q, mid_q;
	logic signed [AW+1:0] right_q;
	logic [AW:0] mid;
	cmp_t cmp;
	logic gt;

	// Midpoint of the live bounds; only used while left <= right, so right is not negative.
	assign mid = (left_q + right_q[AW:0]) >> 1;
	assign search_done = $signed({1'b0, left_q}) > right_q;
	assign shift_done = ptr_q == left_q;
	assign full = cnt_q == (AW+1)'(DEPTH);
	assign left_out = left_q;
	assign mid_out = mid_q;
	assign cnt_out = cnt_q;
	assign rd_data_out = rd_q;

	// Name compare: first differing folded byte, stopping at a shared zero byte.
	always_comb begin
		logic [127:0] a, b;
		logic [7:0] ca, cb;
		logic dn;
		a = {rd_q.name_high, rd_q.name_low};
		b = {qry_q.name_high, qry_q.name_low};
		cmp.name_gt = 1'b0;
		cmp.name_eq = 1'b1;
		dn = 1'b0;
		for (int i = 0; i < 16; i++) begin
			ca = fold(a[127-8*i -: 8]);
			cb = fold(b[127-8*i -: 8]);
			if (!dn) begin
				if (ca != cb) begin
					dn = 1'b1;
					cmp.name_eq = 1'b0;
					cmp.name_gt = ca > cb;
				end else if (ca == 8'd0) begin
					dn = 1'b1;
				end
			end
		end
		cmp.kind_gt = rd_q.kind > qry_q.image_kind;
		cmp.kind_eq = rd_q.kind == qry_q.image_kind;
		cmp.type_lt = rd_q.ctype < qry_q.content_type;
		cmp.type_eq = rd_q.ctype == qry_q.content_type;
	end

	assign hit = cmp.name_eq && cmp.kind_eq &&
		(qry_q.match_mode == MODE_ANY || cmp.type_eq);
	assign gt = cmp.name_gt || (cmp.name_eq && (cmp.kind_gt ||
		(cmp.kind_eq && cmp.type_lt)));

	// Bounds, midpoint, shift pointer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			left_q <= '0;
			right_q <= '0;
			ptr_q <= '0;
			mid_q <= '0;
		end else begin
			if (cap) begin
				left_q <= '0;
				right_q <= {1'b0, cnt_q} - 1'b1;
				ptr_q <= cnt_q;
			end
			if (rd_mid) mid_q <= mid;
			if (step) begin
				if (gt) right_q <= {1'b0, mid_q} - 1'b1;
				else left_q <= mid_q + 1'b1;
			end
			if (wr_shift) ptr_q <= ptr_q - 1'b1;
			if (wr_new) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cap) qry_q <= item_in;
	end

	// Entry memory: one read, one write port.
	always_ff @(posedge clk) begin
		if (rd_mid) rd_q <= mem[mid[AW-1:0]];
		else if (rd_shift) rd_q <= mem[AW'(ptr_q - 1'b1)];
		if (wr_shift) mem[ptr_q[AW-1:0]] <= rd_q;
		else if (wr_new)
			mem[left_q[AW-1:0]] <= '{qry_q.name_high, qry_q.name_low, qry_q.image_kind,
				qry_q.content_type, qry_q.file_position, qry_q.stored_size,
				qry_q.full_size, qry_q.attributes};
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(DEPTH))
		else $error("count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) wr_new |=> cnt_q != 0)
		else $error("count did not grow");
	assert property (@(posedge clk) disable iff (!arst_n) !(wr_shift && wr_new))
		else $error("two writes at once");
endmodule

FILE: src/sntab_ctrl.sv
// Controller of the sorted name table: sequences search, shift and result beat.
// Depends on sntab_pkg.
module sntab_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic action,
	input  logic [1:0] mode,
	input  logic search_done,
	input  logic shift_done,
	input  logic full,
	input  logic hit,
	output logic busy,
	output logic cap,
	output logic rd_mid,
	output logic step,
	output logic rd_shift,
	output logic wr_shift,
	output logic wr_new,
	output logic rd_found,
	output logic done,
	output logic [1:0] status
);
	import sntab_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TEST = 3'd1;
	localparam logic [2:0] S_CMP = 3'd2;
	localparam logic [2:0] S_SHR = 3'd3;
	localparam logic [2:0] S_SHW = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q, state_d;
	logic act_q;
	logic [1:0] mode_q, status_q, status_d;

	assign busy = state_q != S_IDLE;
	assign status = status_q;

	always_comb begin
		state_d = state_q;
		status_d = status_q;
		cap = 1'b0; rd_mid = 1'b0; step = 1'b0; rd_shift = 1'b0;
		wr_shift = 1'b0; wr_new = 1'b0; rd_found = 1'b0; done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cap = 1'b1;
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (act_q == ACT_INSERT && full) begin
					status_d = ST_FULL;
					state_d = S_DONE;
				end else if (act_q == ACT_LOOKUP && mode_q[1]) begin
					status_d = ST_MISS;
					state_d = S_DONE;
				end else if (search_done) begin
					if (act_q == ACT_LOOKUP) begin
						status_d = ST_MISS;
						state_d = S_DONE;
					end else begin
						state_d = S_SHR;
					end
				end else begin
					rd_mid = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (act_q == ACT_LOOKUP && hit) begin
					rd_found = 1'b1;
					status_d = ST_OK;
					state_d = S_DONE;
				end else begin
					step = 1'b1;
					state_d = S_TEST;
				end
			end
			S_SHR: begin
				if (shift_done) begin
					wr_new = 1'b1;
					status_d = ST_OK;
					state_d = S_DONE;
				end else begin
					rd_shift = 1'b1;
					state_d = S_SHW;
				end
			end
			S_SHW: begin
				wr_shift = 1'b1;
				state_d = S_SHR;
			end
			S_DONE: begin
				done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= ST_OK;
			act_q <= 1'b0;
			mode_q <= '0;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
			if (cap) begin
				act_q <= action;
				mode_q <= mode;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("start not taken");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("not idle after result");
	assert property (@(posedge clk) disable iff (!arst_n) wr_shift |-> $past(rd_shift))
		else $error("shift write without read");
endmodule

FILE: src/sorted_name_table_search_insert.sv
// Top level of the sorted name table with binary search and insert.
// Depends on sntab_pkg, sntab_ctrl and sntab_datapath.
// A lookup runs the binary search one step at a time; an insert then moves each
// entry above the new slot up by one, one entry at a time, through the single
// read and write port of the entry memory.
// Raise start while busy is low; each result beat appears for one cycle with
// done high and must be taken then, since the receiver cannot stall the block.
module sorted_name_table_search_insert #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  sntab_pkg::item_t      item,
	output logic                  done,
	output sntab_pkg::result_t    result
);
	import sntab_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);

	logic cap, rd_mid, step, rd_shift, wr_shift, wr_new, rd_found, done_c;
	logic search_done, shift_done, full, hit;
	logic [1:0] status;
	logic [AW:0] left, mid, cnt;
	entry_t rd;
	logic [AW:0] slot_q;
	logic ok_q;
	entry_t fnd_q;

	sntab_ctrl u_ctrl (
		.clk, .arst_n, .start, .action(item.action), .mode(item.match_mode),
		.search_done, .shift_done, .full, .hit, .busy, .cap, .rd_mid, .step,
		.rd_shift, .wr_shift, .wr_new, .rd_found, .done(done_c), .status
	);

	sntab_datapath #(.AW(AW), .DEPTH(MAX_ENTRIES)) u_dp (
		.clk, .arst_n, .item_in(item), .cap, .rd_mid, .step, .rd_shift,
		.wr_shift, .wr_new, .search_done, .shift_done, .full, .hit,
		.left_out(left), .mid_out(mid), .cnt_out(cnt), .rd_data_out(rd)
	);

	// Remember slot and found entry for the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
			slot_q <= '0;
		end else begin
			if (cap) begin
				ok_q <= 1'b0;
				slot_q <= '0;
			end
			if (wr_new) slot_q <= left;
			if (rd_found) begin
				ok_q <= 1'b1;
				slot_q <= mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_found) fnd_q <= rd;
	end

	assign done = done_c;
	always_comb begin
		result = '0;
		result.status = status;
		result.slot = 10'(slot_q);
		result.entry_count = 11'(cnt);
		if (ok_q) begin
			result.found_position = fnd_q.position;
			result.found_stored_size = fnd_q.stored_size;
			result.found_full_size = fnd_q.full_size;
			result.found_attributes = fnd_q.flags;
			result.found_type = fnd_q.ctype;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_FULL |-> result.slot == 10'd0)
		else $error("full with slot");
	assert property (@(posedge clk) disable iff (!arst_n) rd_found |=> ok_q)
		else $error("found flag lost");
endmodule

FILE: verif/sorted_name_table_search_insert_test.sv
// Testbench for the sorted name table: drives insert and lookup beats and
// checks every result beat against a predictor of the sorted table.
// Depends on sntab_pkg and sorted_name_table_search_insert.
`timescale 1ns / 1ps

module sorted_name_table_search_insert_test;
	import sntab_pkg::*;

	localparam int DEPTH = 1024;
	localparam int RESET_CYCLES = 12;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam logic [1:0] MODE_NONE = 2'd2;
	localparam logic [1:0] MODE_NONE_HI = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	item_t item;
	result_t result;

	// Predicted table contents.
	entry_t table_model [DEPTH];
	int unsigned held;

	item_t pending_items [$];
	result_t expected_results [$];
	int mismatches;
	longint cycles;
	int gap;
	int done_wait;

	// Directed corner names.
	logic [63:0] name_pool [8];

	sorted_name_table_search_insert #(.MAX_ENTRIES(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Fold one name byte to lower case.
	function automatic logic [7:0] lower_byte(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a) return c + 8'd32;
		return c;
	endfunction

	// Sign of stored name against query name, stopping at a shared zero byte.
	function automatic int compare_names(input logic [127:0] stored, input logic [127:0] query);
		logic [7:0] a;
		logic [7:0] b;
		for (int i = 0; i < 16; i++) begin
			a = lower_byte(stored[127 - 8 * i -: 8]);
			b = lower_byte(query[127 - 8 * i -: 8]);
			if (a != b) return (a < b) ? -1 : 1;
			if (a == 8'd0) return 0;
		end
		return 0;
	endfunction

	// Apply one beat to the predicted table and return its result.
	function automatic result_t table_step(input item_t it);
		result_t r;
		int lo;
		int hi;
		int mid;
		int diff;
		bit hit;
		r = '0;
		lo = 0;
		hi = int'(held) - 1;
		hit = 1'b0;
		if (it.action == ACT_INSERT) begin
			if (held >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					diff = compare_names({table_model[mid].name_high, table_model[mid].name_low},
						{it.name_high, it.name_low});
					if (diff == 0) begin
						if (table_model[mid].kind > it.image_kind) diff = 1;
						else if (table_model[mid].kind < it.image_kind) diff = -1;
						else if (table_model[mid].ctype < it.content_type) diff = 1;
						else if (table_model[mid].ctype > it.content_type) diff = -1;
					end
					if (diff > 0) hi = mid - 1;
					else lo = mid + 1;
				end
				for (int k = held; k > lo; k--) table_model[k] = table_model[k - 1];
				table_model[lo] = '{it.name_high, it.name_low, it.image_kind, it.content_type,
					it.file_position, it.stored_size, it.full_size, it.attributes};
				held++;
				r.status = ST_OK;
				r.slot = lo[9:0];
			end
		end else begin
			if (it.match_mode == MODE_EXACT || it.match_mode == MODE_ANY) begin
				while (lo <= hi && !hit) begin
					mid = (lo + hi) / 2;
					diff = compare_names({table_model[mid].name_high, table_model[mid].name_low},
						{it.name_high, it.name_low});
					if (diff == 0) begin
						if (table_model[mid].kind > it.image_kind) diff = 1;
						else if (table_model[mid].kind < it.image_kind) diff = -1;
						else if (it.match_mode == MODE_ANY
								|| table_model[mid].ctype == it.content_type) hit = 1'b1;
						else if (table_model[mid].ctype < it.content_type) diff = 1;
						else diff = -1;
					end
					if (!hit) begin
						if (diff > 0) hi = mid - 1;
						else lo = mid + 1;
					end
				end
			end
			if (hit) begin
				r.status = ST_OK;
				r.slot = mid[9:0];
				r.found_position = table_model[mid].position;
				r.found_stored_size = table_model[mid].stored_size;
				r.found_full_size = table_model[mid].full_size;
				r.found_attributes = table_model[mid].flags;
				r.found_type = table_model[mid].ctype;
			end else begin
				r.status = ST_MISS;
			end
		end
		r.entry_count = held[10:0];
		return r;
	endfunction

	// Random beat; names mostly from a small pool so keys collide often.
	function automatic item_t random_item(input bit want_lookup);
		item_t it;
		it.action = want_lookup ? ACT_LOOKUP : ACT_INSERT;
		if ($urandom_range(0, 9) < 7) begin
			it.name_high = name_pool[$urandom_range(0, 7)];
			it.name_low = ($urandom_range(0, 2) == 0) ? 64'd0 : name_pool[$urandom_range(0, 7)];
		end else begin
			it.name_high = {$urandom, $urandom};
			it.name_low = {$urandom, $urandom};
		end
		// Flip letter case now and then so folding is exercised.
		if ($urandom_range(0, 1)) it.name_high = it.name_high ^ 64'h2020_2020_0000_0000;
		it.image_kind = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(0, 3));
		it.content_type = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		it.match_mode = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom);
		it.file_position = $urandom;
		it.stored_size = $urandom;
		it.full_size = $urandom;
		it.attributes = 8'($urandom);
		return it;
	endfunction

	// Driver: raise start with the next queued beat after a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap <= 0;
		end else if (start && !busy) begin
			start <= 1'b0;
			gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		end else if (!start) begin
			if (gap > 0) begin
				gap <= gap - 1;
			end else if (pending_items.size() > 0) begin
				item <= pending_items[0];
				expected_results.push_back(table_step(pending_items[0]));
				void'(pending_items.pop_front());
				start <= 1'b1;
			end
		end
	end

	// Monitor: every done beat is checked against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result beat %p", result);
			end else begin
				want = expected_results.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected %p, got %p", want, result);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		item_t it;
		int lookups_left;
		arst_n = 1'b0;
		mismatches = 0;
		cycles = 0;
		held = 0;
		// Names start at the top byte, zero padded below.
		name_pool[0] = {"abc", 40'h0};
		name_pool[1] = {"ABD", 40'h0};
		name_pool[2] = {"zz", 48'h0};
		name_pool[3] = 64'h0;
		name_pool[4] = 64'hffff_ffff_ffff_ffff;
		name_pool[5] = {"Ab@[`{", 16'h0};
		name_pool[6] = 64'h6100_7f80_0000_0000;
		name_pool[7] = 64'h6100_0180_0000_0000;

		// Directed: lookup in the empty table, field extremes, case folding,
		// duplicate keys, both match modes, the not-found modes and a wild kind.
		it = '0;
		it.action = ACT_LOOKUP;
		pending_items.push_back(it);
		for (int i = 0; i < 8; i++) begin
			it = '0;
			it.action = ACT_INSERT;
			it.name_high = name_pool[i];
			it.name_low = (i % 2) ? 64'hffff_ffff_ffff_ffff : 64'h0;
			it.image_kind = (i == 4) ? 4'd15 : 4'(i);
			it.content_type = (i % 3 == 0) ? 8'hff : 8'(i);
			it.file_position = (i == 4) ? 32'hffff_ffff : 32'(i);
			it.stored_size = (i == 4) ? 32'hffff_ffff : 32'(i * 7);
			it.full_size = (i == 4) ? 32'hffff_ffff : 32'(i * 9);
			it.attributes = (i == 4) ? 8'hff : 8'(i);
			pending_items.push_back(it);
		end
		it.name_high = {"ABC", 40'h0};
		it.name_low = 64'h0;
		it.image_kind = 4'd0;
		it.content_type = 8'hff;
		pending_items.push_back(it);
		it.content_type = 8'h00;
		pending_items.push_back(it);
		it.action = ACT_LOOKUP;
		it.match_mode = MODE_EXACT;
		pending_items.push_back(it);
		it.match_mode = MODE_ANY;
		pending_items.push_back(it);
		it.match_mode = MODE_NONE;
		pending_items.push_back(it);
		it.match_mode = MODE_NONE_HI;
		pending_items.push_back(it);
		it.name_high = name_pool[4];
		it.name_low = 64'hffff_ffff_ffff_ffff;
		it.image_kind = 4'd15;
		it.match_mode = MODE_ANY;
		pending_items.push_back(it);
		it.image_kind = 4'd14;
		pending_items.push_back(it);
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Random mix of inserts and lookups.
		for (int n = 0; n < 530; n++)
			pending_items.push_back(random_item($urandom_range(0, 9) < 4));
		wait (pending_items.size() == 0);

		// Close with lookups against the grown table.
		lookups_left = 20;
		for (int n = 0; n < lookups_left; n++) pending_items.push_back(random_item(1'b1));
		wait (pending_items.size() == 0);
		wait (start == 1'b0);
		wait (expected_results.size() == 0);
		done_wait = 0;
		while (done_wait < 2 * DEPTH + 50) begin
			@(posedge clk);
			done_wait++;
		end
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
